// File: hdl/vpps_pkg.sv
// Shared types, constants, saturation helpers and microcode ROM of the velocity PID step.
`default_nettype none

package vpps_pkg;

    localparam int WORD_BITS      = 32;
    localparam int FRAC_BITS      = 16;
    localparam int PERIOD_FRAC    = 16;
    localparam int INTEG_BITS     = 48;
    localparam int TICK_BITS      = 20;
    localparam int PERIOD_BITS    = 16;
    localparam int GAIN_BITS      = 32;
    localparam int CFG_DATA_BITS  = 32;
    localparam int CFG_INDEX_BITS = 3;

    // Multiplier: signed operand one bit wider than the integral, magnitude times a 32-bit gain
    localparam int OPND_BITS = INTEG_BITS + 1;
    localparam int MAG_BITS  = INTEG_BITS;
    localparam int HALF_BITS = GAIN_BITS;
    localparam int PROD_BITS = 2 * HALF_BITS;
    localparam int ACC_BITS  = MAG_BITS + GAIN_BITS;
    localparam int SUM_BITS  = INTEG_BITS + 2;
    localparam int DV_BITS   = WORD_BITS + 2;

    localparam logic [TICK_BITS-1:0] TICK_MAX = '1;

    localparam logic signed [WORD_BITS-1:0] WORD_MAX = {1'b0, {(WORD_BITS-1){1'b1}}};
    localparam logic signed [WORD_BITS-1:0] WORD_MIN = {1'b1, {(WORD_BITS-1){1'b0}}};
    localparam logic [MAG_BITS-1:0] MAG_WORD_POS =
        (MAG_BITS'(1) << (WORD_BITS - 1)) - MAG_BITS'(1);
    localparam logic [MAG_BITS-1:0] MAG_WORD_NEG = MAG_BITS'(1) << (WORD_BITS - 1);

    // Program layout: two subtract steps, six multiply blocks, one delivery step
    localparam int MUL_LEN  = 6;
    localparam int PH_LOAD  = 0;
    localparam int PH_MLO   = 1;
    localparam int PH_MHI   = 2;
    localparam int PH_ACC   = 3;
    localparam int PH_RND   = 4;
    localparam int PH_WB    = 5;
    localparam int S_ESUB   = 0;
    localparam int S_DESUB  = 1;
    localparam int S_INT    = 2;
    localparam int S_ACCEL  = S_INT + MUL_LEN;
    localparam int S_PTERM  = S_ACCEL + MUL_LEN;
    localparam int S_ITERM  = S_PTERM + MUL_LEN;
    localparam int S_DTERM  = S_ITERM + MUL_LEN;
    localparam int S_CMD    = S_DTERM + MUL_LEN;
    localparam int S_DONE   = S_CMD + MUL_LEN;
    localparam int UCODE_LEN = S_DONE + 1;
    localparam int STEP_BITS = $clog2(UCODE_LEN);

    typedef enum logic {
        CMD_TICK  = 1'b0,
        CMD_START = 1'b1
    } cmd_t;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_REF_LEVEL,
        CFG_HOLD_END,
        CFG_STOP,
        CFG_GAIN_P,
        CFG_GAIN_I,
        CFG_GAIN_D,
        CFG_PERIOD,
        CFG_INV_PERIOD
    } cfg_idx_t;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_ESUB,
        OP_DESUB,
        OP_LOAD,
        OP_MLO,
        OP_MHI,
        OP_ACC,
        OP_RND,
        OP_WB,
        OP_DONE
    } uop_t;

    typedef enum logic [2:0] {
        SRC_E,
        SRC_VDIFF,
        SRC_INTEG,
        SRC_DE,
        SRC_DV
    } src_t;

    typedef enum logic [2:0] {
        G_PERIOD,
        G_INV,
        G_P,
        G_I,
        G_D
    } gsel_t;

    typedef enum logic {
        SH_FRAC,
        SH_PERIOD
    } shsel_t;

    typedef enum logic [2:0] {
        DST_INTEG,
        DST_ACCEL,
        DST_DVSET,
        DST_DVADD,
        DST_CMD
    } dst_t;

    typedef struct packed {
        uop_t                 op;
        src_t                 src;
        gsel_t                gsel;
        shsel_t               sh;
        dst_t                 dst;
        logic                 jnarrow;
        logic [STEP_BITS-1:0] target;
    } ctrl_t;

    typedef ctrl_t [UCODE_LEN-1:0] ucode_t;

    localparam ctrl_t CTRL_IDLE = '0;

    typedef struct packed {
        logic signed [WORD_BITS-1:0] ref_level;
        logic [TICK_BITS-1:0]        hold_end;
        logic [TICK_BITS-1:0]        stop;
        logic [GAIN_BITS-1:0]        gain_p;
        logic [GAIN_BITS-1:0]        gain_i;
        logic [GAIN_BITS-1:0]        gain_d;
        logic [PERIOD_BITS-1:0]      period;
        logic [GAIN_BITS-1:0]        inv_period;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        ref_level:  32'sd131072,
        hold_end:   20'd6000,
        stop:       20'd7000,
        gain_p:     32'd58982400,
        gain_i:     32'd0,
        gain_d:     32'd0,
        period:     16'd655,
        inv_period: 32'd6553600
    };

    function automatic logic signed [WORD_BITS-1:0] sat_word(
        input logic signed [SUM_BITS-1:0] x
    );
        logic [SUM_BITS-WORD_BITS:0] upper;
        upper = x[SUM_BITS-1:WORD_BITS-1];
        if (upper == '0 || upper == '1) begin
            return x[WORD_BITS-1:0];
        end else if (x[SUM_BITS-1]) begin
            return WORD_MIN;
        end else begin
            return WORD_MAX;
        end
    endfunction

    function automatic logic signed [INTEG_BITS-1:0] sat_integ(
        input logic signed [SUM_BITS-1:0] x
    );
        logic [SUM_BITS-INTEG_BITS:0] upper;
        upper = x[SUM_BITS-1:INTEG_BITS-1];
        if (upper == '0 || upper == '1) begin
            return x[INTEG_BITS-1:0];
        end else if (x[SUM_BITS-1]) begin
            return {1'b1, {(INTEG_BITS-1){1'b0}}};
        end else begin
            return {1'b0, {(INTEG_BITS-1){1'b1}}};
        end
    endfunction

    // Saturate a sign and magnitude pair to a word
    function automatic logic signed [WORD_BITS-1:0] sat_mag_word(
        input logic                neg,
        input logic [MAG_BITS-1:0] q
    );
        logic [WORD_BITS-1:0] low;
        low = q[WORD_BITS-1:0];
        if (!neg) begin
            return (q > MAG_WORD_POS) ? WORD_MAX : low;
        end else begin
            return (q > MAG_WORD_NEG) ? WORD_MIN : (~low) + WORD_BITS'(1);
        end
    endfunction

    function automatic ucode_t mul_block(
        input ucode_t u_in,
        input int     base,
        input src_t   s,
        input gsel_t  g,
        input shsel_t sh,
        input dst_t   d
    );
        ucode_t u;
        u = u_in;
        u[base + PH_LOAD].op      = OP_LOAD;
        u[base + PH_LOAD].src     = s;
        u[base + PH_LOAD].gsel    = g;
        u[base + PH_MLO].op       = OP_MLO;
        u[base + PH_MHI].op       = OP_MHI;
        u[base + PH_MHI].jnarrow  = 1'b1;
        u[base + PH_MHI].target   = STEP_BITS'(base + PH_RND);
        u[base + PH_ACC].op       = OP_ACC;
        u[base + PH_RND].op       = OP_RND;
        u[base + PH_RND].sh       = sh;
        u[base + PH_WB].op        = OP_WB;
        u[base + PH_WB].dst       = d;
        return u;
    endfunction

    function automatic ucode_t build_ucode();
        ucode_t u;
        u = '0;
        u[S_ESUB].op  = OP_ESUB;
        u[S_DESUB].op = OP_DESUB;
        u = mul_block(u, S_INT,   SRC_E,     G_PERIOD, SH_PERIOD, DST_INTEG);
        u = mul_block(u, S_ACCEL, SRC_VDIFF, G_INV,    SH_FRAC,   DST_ACCEL);
        u = mul_block(u, S_PTERM, SRC_E,     G_P,      SH_FRAC,   DST_DVSET);
        u = mul_block(u, S_ITERM, SRC_INTEG, G_I,      SH_FRAC,   DST_DVADD);
        u = mul_block(u, S_DTERM, SRC_DE,    G_D,      SH_FRAC,   DST_DVADD);
        u = mul_block(u, S_CMD,   SRC_DV,    G_PERIOD, SH_PERIOD, DST_CMD);
        u[S_DONE].op  = OP_DONE;
        return u;
    endfunction

    localparam ucode_t UCODE = build_ucode();

endpackage

`default_nettype wire

// File: hdl/vpps_seq.sv
// Microcode sequencer: step counter, program ROM and conditional jump.
`default_nettype none

module vpps_seq
    import vpps_pkg::*;
(
    input  wire logic  aclk,
    input  wire logic  aresetn,
    input  wire logic  start,
    input  wire logic  narrow,
    input  wire logic  hold,
    output ctrl_t      ctrl,
    output logic       busy
);

    logic                 run_reg, run_next;
    logic [STEP_BITS-1:0] step_reg, step_next;
    ctrl_t                word;

    assign word = UCODE[step_reg];
    assign ctrl = run_reg ? word : CTRL_IDLE;
    assign busy = run_reg;

    always_comb begin
        run_next  = run_reg;
        step_next = step_reg;
        if (!run_reg) begin
            if (start) begin
                run_next  = 1'b1;
                step_next = '0;
            end
        end else if (word.op == OP_DONE) begin
            // stay on the delivery step until the output register is free
            if (!hold) begin
                run_next = 1'b0;
            end
        end else if (word.jnarrow && narrow) begin
            step_next = word.target;
        end else begin
            step_next = step_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg  <= 1'b0;
            step_reg <= '0;
        end else begin
            run_reg  <= run_next;
            step_reg <= step_next;
        end
    end

endmodule

`default_nettype wire

// File: hdl/vpps_mul.sv
// Shared multiply unit: sign-magnitude 48 x 32 product in two halves, rounding and clipping.
`default_nettype none

module vpps_mul
    import vpps_pkg::*;
(
    input  wire logic                        aclk,
    input  wire ctrl_t                       ctrl,
    input  wire logic signed [OPND_BITS-1:0] operand,
    input  wire logic [GAIN_BITS-1:0]        gain,
    output logic                             narrow,
    output logic                             neg,
    output logic [MAG_BITS-1:0]              q
);

    localparam logic [ACC_BITS:0] RND_FRAC   = (ACC_BITS+1)'(1) << (FRAC_BITS - 1);
    localparam logic [ACC_BITS:0] RND_PERIOD = (ACC_BITS+1)'(1) << (PERIOD_FRAC - 1);

    logic                  neg_reg, neg_next;
    logic [MAG_BITS-1:0]   mag_reg, mag_next;
    logic [MAG_BITS-1:0]   q_reg, q_next;
    logic [GAIN_BITS-1:0]  gain_reg, gain_next;
    logic [PROD_BITS-1:0]  prod_reg, prod_next;
    logic [ACC_BITS-1:0]   acc_reg, acc_next;
    logic [OPND_BITS-1:0]  opnd_abs;
    logic [HALF_BITS-1:0]  mul_a;
    logic [PROD_BITS-1:0]  product;
    logic [ACC_BITS:0]     rnd;
    logic [ACC_BITS:0]     shifted;

    assign narrow = ~|mag_reg[MAG_BITS-1:HALF_BITS];
    assign neg    = neg_reg;
    assign q      = q_reg;

    // low half of the magnitude first, high half on the following step
    assign mul_a   = (ctrl.op == OP_MHI) ? HALF_BITS'(mag_reg[MAG_BITS-1:HALF_BITS])
                                         : mag_reg[HALF_BITS-1:0];
    assign product = mul_a * gain_reg;

    always_comb begin
        opnd_abs = operand[OPND_BITS-1] ? (~operand) + OPND_BITS'(1) : operand;
        rnd      = {1'b0, acc_reg} + ((ctrl.sh == SH_FRAC) ? RND_FRAC : RND_PERIOD);
        shifted  = (ctrl.sh == SH_FRAC) ? (rnd >> FRAC_BITS) : (rnd >> PERIOD_FRAC);
    end

    always_comb begin
        neg_next  = neg_reg;
        mag_next  = mag_reg;
        gain_next = gain_reg;
        prod_next = prod_reg;
        acc_next  = acc_reg;
        q_next    = q_reg;
        unique case (ctrl.op)
            OP_LOAD: begin
                neg_next  = operand[OPND_BITS-1];
                mag_next  = opnd_abs[MAG_BITS-1:0];
                gain_next = gain;
            end
            OP_MLO: begin
                prod_next = product;
            end
            OP_MHI: begin
                acc_next  = ACC_BITS'(prod_reg);
                prod_next = product;
            end
            OP_ACC: begin
                acc_next = acc_reg + {prod_reg[ACC_BITS-HALF_BITS-1:0], {HALF_BITS{1'b0}}};
            end
            OP_RND: begin
                // clip to the largest magnitude; every consumer saturates below it
                q_next = (|shifted[ACC_BITS:MAG_BITS]) ? '1 : shifted[MAG_BITS-1:0];
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        neg_reg  <= neg_next;
        mag_reg  <= mag_next;
        gain_reg <= gain_next;
        prod_reg <= prod_next;
        acc_reg  <= acc_next;
        q_reg    <= q_next;
    end

endmodule

`default_nettype wire

// File: hdl/vpps_dp.sv
// Controller datapath: error, integral, PID terms, command and acceleration registers.
`default_nettype none

module vpps_dp
    import vpps_pkg::*;
(
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire ctrl_t                       ctrl,
    input  wire cfg_t                        cfg,
    input  wire logic                        start,
    input  wire logic signed [WORD_BITS-1:0] v_in,
    input  wire logic signed [WORD_BITS-1:0] ref_in,
    input  wire logic                        neg,
    input  wire logic [MAG_BITS-1:0]         q,
    output logic signed [OPND_BITS-1:0]      operand,
    output logic [GAIN_BITS-1:0]             gain,
    output logic signed [WORD_BITS-1:0]      command_velocity,
    output logic signed [WORD_BITS-1:0]      reference_velocity,
    output logic signed [WORD_BITS-1:0]      acceleration
);

    logic signed [INTEG_BITS-1:0] integ_reg, integ_next;
    logic signed [WORD_BITS-1:0]  prev_err_reg, prev_err_next;
    logic signed [WORD_BITS-1:0]  prev_v_reg, prev_v_next;
    logic signed [WORD_BITS-1:0]  v_reg, v_next;
    logic signed [WORD_BITS-1:0]  ref_reg, ref_next;
    logic signed [WORD_BITS-1:0]  e_reg, e_next;
    logic signed [WORD_BITS-1:0]  de_reg, de_next;
    logic signed [DV_BITS-1:0]    dv_reg, dv_next;
    logic signed [WORD_BITS-1:0]  accel_reg, accel_next;
    logic signed [WORD_BITS-1:0]  cmd_reg, cmd_next;
    logic signed [SUM_BITS-1:0]   sq;
    logic signed [WORD_BITS-1:0]  term;

    assign command_velocity   = cmd_reg;
    assign reference_velocity = ref_reg;
    assign acceleration       = accel_reg;

    always_comb begin
        sq = $signed({{(SUM_BITS-MAG_BITS){1'b0}}, q});
        if (neg) begin
            sq = -sq;
        end
        term = sat_mag_word(neg, q);
    end

    always_comb begin
        unique case (ctrl.src)
            SRC_E:     operand = OPND_BITS'(e_reg);
            SRC_VDIFF: operand = OPND_BITS'(v_reg) - OPND_BITS'(prev_v_reg);
            SRC_INTEG: operand = OPND_BITS'(integ_reg);
            SRC_DE:    operand = OPND_BITS'(de_reg);
            SRC_DV:    operand = OPND_BITS'(sat_word(SUM_BITS'(dv_reg)));
            default:   operand = '0;
        endcase
        unique case (ctrl.gsel)
            G_PERIOD: gain = GAIN_BITS'(cfg.period);
            G_INV:    gain = cfg.inv_period;
            G_P:      gain = cfg.gain_p;
            G_I:      gain = cfg.gain_i;
            G_D:      gain = cfg.gain_d;
            default:  gain = '0;
        endcase
    end

    always_comb begin
        integ_next    = integ_reg;
        prev_err_next = prev_err_reg;
        prev_v_next   = prev_v_reg;
        v_next        = v_reg;
        ref_next      = ref_reg;
        e_next        = e_reg;
        de_next       = de_reg;
        dv_next       = dv_reg;
        accel_next    = accel_reg;
        cmd_next      = cmd_reg;
        if (start) begin
            v_next   = v_in;
            ref_next = ref_in;
        end
        unique case (ctrl.op)
            OP_ESUB: begin
                e_next = sat_word(SUM_BITS'(ref_reg) - SUM_BITS'(v_reg));
            end
            OP_DESUB: begin
                de_next = sat_word(SUM_BITS'(e_reg) - SUM_BITS'(prev_err_reg));
            end
            OP_WB: begin
                unique case (ctrl.dst)
                    DST_INTEG: integ_next = sat_integ(SUM_BITS'(integ_reg) + sq);
                    DST_ACCEL: accel_next = term;
                    DST_DVSET: dv_next    = DV_BITS'(term);
                    DST_DVADD: dv_next    = dv_reg + DV_BITS'(term);
                    DST_CMD:   cmd_next   = sat_word(SUM_BITS'(v_reg) + sq);
                    default: begin
                    end
                endcase
            end
            OP_DONE: begin
                // advance the history for the next tick
                prev_err_next = e_reg;
                prev_v_next   = v_reg;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            integ_reg    <= '0;
            prev_err_reg <= '0;
            prev_v_reg   <= '0;
        end else begin
            integ_reg    <= integ_next;
            prev_err_reg <= prev_err_next;
            prev_v_reg   <= prev_v_next;
        end
    end

    always_ff @(posedge aclk) begin
        v_reg     <= v_next;
        ref_reg   <= ref_next;
        e_reg     <= e_next;
        de_reg    <= de_next;
        dv_reg    <= dv_next;
        accel_reg <= accel_next;
        cmd_reg   <= cmd_next;
    end

endmodule

`default_nettype wire

// File: hdl/velocity_profile_pid_step.sv
// Top level of the velocity PID step: handshakes, configuration, run timing and output register.
//
// Usage:
//   Input channel s_*: cmd = start arms a run and clears the tick count; cmd = tick
//   carries one measured velocity (signed Q16.16). A tick while armed gives one result
//   item on m_*: command velocity, the reference used, the acceleration estimate and
//   a finished flag on the tick that ends the run. Other items give no result.
//   Configuration: write cfg_data to register cfg_index while cfg_we is high; write
//   only while no item is in flight.
//   Program: a tick item runs a 39-step microprogram on one shared 32 x 32 multiplier,
//   six products of five to six steps each; the integral's product takes the sixth
//   step (a second partial sum) when its magnitude reaches 2^32. s_ready is low while
//   the program runs, so no new item is taken until the program ends; start items and
//   idle ticks are taken every cycle while no program runs.
//   A stalled receiver holds the result in the output register; the next item is
//   still accepted and its program waits on the last step until the register frees.
//   Reset (aresetn low, synchronous) disarms the run, clears the tick count, integral
//   and history, drops m_valid and restores the default register values.
`default_nettype none

module velocity_profile_pid_step
    import vpps_pkg::*;
(
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic                          s_cmd,
    input  wire logic signed [WORD_BITS-1:0]   s_measured_velocity,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic signed [WORD_BITS-1:0]        m_command_velocity,
    output logic signed [WORD_BITS-1:0]        m_reference_velocity,
    output logic signed [WORD_BITS-1:0]        m_acceleration,
    output logic                               m_finished,
    input  wire logic                          cfg_we,
    input  wire logic [CFG_INDEX_BITS-1:0]     cfg_index,
    input  wire logic [CFG_DATA_BITS-1:0]      cfg_data
);

    cfg_t                        cfg_reg, cfg_next;
    logic [TICK_BITS-1:0]        tick_reg, tick_next;
    logic                        active_reg, active_next;
    logic                        fin_reg, fin_next;
    logic                        m_valid_reg, m_valid_next;
    logic signed [WORD_BITS-1:0] m_cmd_reg, m_cmd_next;
    logic signed [WORD_BITS-1:0] m_ref_reg, m_ref_next;
    logic signed [WORD_BITS-1:0] m_acc_reg, m_acc_next;
    logic                        m_fin_reg, m_fin_next;

    logic                        accept;
    logic                        start;
    logic                        in_hold;
    logic signed [WORD_BITS-1:0] ref_sel;
    logic                        out_free;
    logic                        load_out;
    ctrl_t                       ctrl;
    logic                        busy;
    logic                        narrow;
    logic                        mul_neg;
    logic [MAG_BITS-1:0]         mul_q;
    logic signed [OPND_BITS-1:0] operand;
    logic [GAIN_BITS-1:0]        gain;
    logic signed [WORD_BITS-1:0] dp_cmd;
    logic signed [WORD_BITS-1:0] dp_ref;
    logic signed [WORD_BITS-1:0] dp_acc;

    assign s_ready  = !busy;
    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign load_out = (ctrl.op == OP_DONE) && out_free;

    assign m_valid              = m_valid_reg;
    assign m_command_velocity   = m_cmd_reg;
    assign m_reference_velocity = m_ref_reg;
    assign m_acceleration       = m_acc_reg;
    assign m_finished           = m_fin_reg;

    // level while within the hold time, zero afterwards
    assign in_hold = tick_reg <= cfg_reg.hold_end;
    assign ref_sel = in_hold ? cfg_reg.ref_level : '0;

    always_comb begin
        tick_next   = tick_reg;
        active_next = active_reg;
        fin_next    = fin_reg;
        start       = 1'b0;
        if (accept) begin
            if (s_cmd == CMD_START) begin
                tick_next   = '0;
                active_next = 1'b1;
            end else if (active_reg) begin
                start = 1'b1;
                if (tick_reg != TICK_MAX) begin
                    tick_next = tick_reg + 1'b1;
                end
                fin_next = !in_hold && (tick_reg > cfg_reg.stop);
                if (fin_next) begin
                    active_next = 1'b0;
                end
            end
        end
    end

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_we) begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_REF_LEVEL:  cfg_next.ref_level  = cfg_data[WORD_BITS-1:0];
                CFG_HOLD_END:   cfg_next.hold_end   = cfg_data[TICK_BITS-1:0];
                CFG_STOP:       cfg_next.stop       = cfg_data[TICK_BITS-1:0];
                CFG_GAIN_P:     cfg_next.gain_p     = cfg_data[GAIN_BITS-1:0];
                CFG_GAIN_I:     cfg_next.gain_i     = cfg_data[GAIN_BITS-1:0];
                CFG_GAIN_D:     cfg_next.gain_d     = cfg_data[GAIN_BITS-1:0];
                CFG_PERIOD:     cfg_next.period     = cfg_data[PERIOD_BITS-1:0];
                CFG_INV_PERIOD: cfg_next.inv_period = cfg_data[GAIN_BITS-1:0];
            endcase
        end
    end

    always_comb begin
        m_cmd_next = m_cmd_reg;
        m_ref_next = m_ref_reg;
        m_acc_next = m_acc_reg;
        m_fin_next = m_fin_reg;
        if (load_out) begin
            m_valid_next = 1'b1;
            m_cmd_next   = dp_cmd;
            m_ref_next   = dp_ref;
            m_acc_next   = dp_acc;
            m_fin_next   = fin_reg;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg     <= CFG_RESET;
            tick_reg    <= '0;
            active_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            cfg_reg     <= cfg_next;
            tick_reg    <= tick_next;
            active_reg  <= active_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        fin_reg   <= fin_next;
        m_cmd_reg <= m_cmd_next;
        m_ref_reg <= m_ref_next;
        m_acc_reg <= m_acc_next;
        m_fin_reg <= m_fin_next;
    end

    vpps_seq u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (start),
        .narrow  (narrow),
        .hold    (!out_free),
        .ctrl    (ctrl),
        .busy    (busy)
    );

    vpps_mul u_mul (
        .aclk    (aclk),
        .ctrl    (ctrl),
        .operand (operand),
        .gain    (gain),
        .narrow  (narrow),
        .neg     (mul_neg),
        .q       (mul_q)
    );

    vpps_dp u_dp (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .ctrl               (ctrl),
        .cfg                (cfg_reg),
        .start              (start),
        .v_in               (s_measured_velocity),
        .ref_in             (ref_sel),
        .neg                (mul_neg),
        .q                  (mul_q),
        .operand            (operand),
        .gain               (gain),
        .command_velocity   (dp_cmd),
        .reference_velocity (dp_ref),
        .acceleration       (dp_acc)
    );

endmodule

`default_nettype wire
